// File: rtl/slt_pkg.sv
package slt_pkg;

    localparam int VALUE_W    = 32;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

// File: rtl/slt_ram.sv
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sorted_linked_list_table.sv
// sorted list table: a sorted doubly linked list of 32-bit signed values kept in a
// node store of CAPACITY entries with a free list. each input word is one command
// (add, remove slot, read slot, search value) and gives exactly one result word that
// also carries the element count. after reset the block runs a clearing pass over
// all CAPACITY entries that rebuilds the free chain; no word is taken until it ends
// (sort order writes are taken at any time). read and remove look up the slot's
// node, and remove then unlinks it and pushes it onto the free list; add pops the
// free list and walks the list to the insert point, and search walks it until the
// value or the end is met: the walk makes one read of the value and link memories
// per cycle. a result waits in an output register while the next command is taken.
module sorted_linked_list_table #(
    parameter int CAPACITY = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sort order register: 0 non-decreasing, 1 non-increasing
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // value [31:0], slot [37:32], zero pad [39:38]
    input  logic [slt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command [1:0]
    input  logic [slt_pkg::CMD_W-1:0]       s_axis_tuser,
    // result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_value [31:0], result_slot [37:32], slot_present [38], count [45:39], pad
    output logic [slt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [slt_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import slt_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NONE = LW'(CAPACITY);

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_ADD1  = 10'b0000000100,
        S_WALK  = 10'b0000001000,
        S_LINK0 = 10'b0000010000,
        S_LINK1 = 10'b0000100000,
        S_RD1   = 10'b0001000000,
        S_RM1   = 10'b0010000000,
        S_RM2   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_clr, n_clr;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_fh, n_fh;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_sort;
    t_cmd                  r_cmd, n_cmd;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic [IW-1:0]         r_idx, n_idx;
    logic [LW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_prv, n_prv;
    logic [LW-1:0]         r_nx, n_nx;
    t_status               r_res_st, n_res_st;
    logic [VALUE_W-1:0]    r_res_val, n_res_val;
    logic [IW-1:0]         r_res_slot, n_res_slot;
    logic                  r_res_pres, n_res_pres;
    logic                  r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;
    logic [STATUS_W-1:0]   r_ouser, n_ouser;

    // memory ports
    logic [IW-1:0]      raddr;
    logic               d_we, n_we, p_we;
    logic [IW-1:0]      d_wa, n_wa, p_wa;
    logic [VALUE_W-1:0] d_wd, d_rd;
    logic [LW-1:0]      n_wd, n_rd;
    logic [LW:0]        p_wd, p_rd;

    t_cmd               in_cmd;
    logic [VALUE_W-1:0] in_val;
    logic [SLOT_W-1:0]  in_slot;
    logic               holds;
    logic               load_out;

    // value store, next links, and {used, prev link}
    slt_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_dmem (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(raddr), .o_rdata(d_rd)
    );
    slt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_nmem (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(n_wd),
        .i_raddr(raddr), .o_rdata(n_rd)
    );
    slt_ram #(.WIDTH(LW + 1), .DEPTH(CAPACITY)) u_pmem (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(raddr), .o_rdata(p_rd)
    );

    assign in_cmd  = t_cmd'(s_axis_tuser);
    assign in_val  = s_axis_tdata[VALUE_W-1:0];
    assign in_slot = s_axis_tdata[VALUE_W +: SLOT_W];

    // stored value may stand before the new one
    assign holds = r_sort ? ($signed(d_rd) >= $signed(r_val))
                          : ($signed(d_rd) <= $signed(r_val));

    assign load_out = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // every command is a sequence of reads and writes, add and search with a walk of
    // variable length; no read result is used from an entry written in the same cycle, so no forwarding is needed
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_head     = r_head;
        n_fh       = r_fh;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_prv      = r_prv;
        n_nx       = r_nx;
        n_res_st   = r_res_st;
        n_res_val  = r_res_val;
        n_res_slot = r_res_slot;
        n_res_pres = r_res_pres;
        raddr      = r_cur[IW-1:0];
        d_we = 1'b0;  d_wa = r_idx;  d_wd = r_val;
        n_we = 1'b0;  n_wa = '0;     n_wd = '0;
        p_we = 1'b0;  p_wa = '0;     p_wd = '0;

        case (r_state)
            S_CLR: begin
                // free chain i to i plus 1, all prev links none, all unused
                n_we  = 1'b1;
                n_wa  = r_clr;
                n_wd  = {1'b0, r_clr} + LW'(1);
                p_we  = 1'b1;
                p_wa  = r_clr;
                p_wd  = {1'b0, NONE};
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd      = in_cmd;
                    n_val      = in_val;
                    n_res_val  = '0;
                    n_res_slot = '0;
                    n_res_pres = 1'b0;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (r_fh == NONE) begin
                                n_res_st = ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                raddr   = r_fh[IW-1:0];
                                d_we    = 1'b1;
                                d_wa    = r_fh[IW-1:0];
                                d_wd    = in_val;
                                n_idx   = r_fh[IW-1:0];
                                n_cur   = r_head;
                                n_prv   = NONE;
                                n_state = S_ADD1;
                            end
                        end
                        CMD_REMOVE, CMD_READ: begin
                            if (32'(in_slot) >= CAPACITY) begin
                                n_res_st = ST_INVALID;
                                n_state  = S_OUT;
                            end else begin
                                raddr   = IW'(in_slot);
                                n_cur   = {1'b0, IW'(in_slot)};
                                n_state = S_RD1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_head == NONE) begin
                                n_res_st = ST_NOT_FOUND;
                                n_state  = S_OUT;
                            end else begin
                                raddr   = r_head[IW-1:0];
                                n_cur   = r_head;
                                n_state = S_WALK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD1: begin
                // pop the free list
                n_fh = n_rd;
                if (n_rd != NONE) begin
                    p_we = 1'b1;
                    p_wa = n_rd[IW-1:0];
                    p_wd = {1'b0, NONE};
                end
                if (r_cur == NONE) begin
                    n_state = S_LINK0;
                end else begin
                    raddr   = r_cur[IW-1:0];
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_SEARCH) begin
                    if (d_rd == r_val) begin
                        n_res_st   = ST_OK;
                        n_res_slot = r_cur[IW-1:0];
                        n_res_pres = 1'b1;
                        n_state    = S_OUT;
                    end else if (n_rd != NONE) begin
                        n_cur = n_rd;
                        raddr = n_rd[IW-1:0];
                    end else begin
                        n_res_st = ST_NOT_FOUND;
                        n_state  = S_OUT;
                    end
                end else if (holds) begin
                    n_prv = r_cur;
                    n_cur = n_rd;
                    if (n_rd != NONE) begin
                        raddr = n_rd[IW-1:0];
                    end else begin
                        n_state = S_LINK0;
                    end
                end else begin
                    n_state = S_LINK0;
                end
            end
            S_LINK0: begin
                n_we = 1'b1;
                n_wa = r_idx;
                n_wd = r_cur;
                if (r_cur != NONE) begin
                    p_we = 1'b1;
                    p_wa = r_cur[IW-1:0];
                    p_wd = {1'b1, 1'b0, r_idx};
                end
                n_state = S_LINK1;
            end
            S_LINK1: begin
                if (r_prv != NONE) begin
                    n_we = 1'b1;
                    n_wa = r_prv[IW-1:0];
                    n_wd = {1'b0, r_idx};
                end else begin
                    n_head = {1'b0, r_idx};
                end
                p_we       = 1'b1;
                p_wa       = r_idx;
                p_wd       = {1'b1, r_prv};
                n_count    = r_count + CW'(1);
                n_res_st   = ST_OK;
                n_res_slot = r_idx;
                n_res_pres = 1'b1;
                n_state    = S_OUT;
            end
            S_RD1: begin
                if (!p_rd[LW]) begin
                    n_res_st = ST_INVALID;
                    n_state  = S_OUT;
                end else if (r_cmd == CMD_READ) begin
                    n_res_st  = ST_OK;
                    n_res_val = d_rd;
                    n_state   = S_OUT;
                end else begin
                    // unlink from its neighbors
                    n_res_val = d_rd;
                    n_nx      = n_rd;
                    if (p_rd[LW-1:0] != NONE) begin
                        n_we = 1'b1;
                        n_wa = p_rd[IW-1:0];
                        n_wd = n_rd;
                    end else begin
                        n_head = n_rd;
                    end
                    if (n_rd != NONE) begin
                        p_we = 1'b1;
                        p_wa = n_rd[IW-1:0];
                        p_wd = {1'b1, p_rd[LW-1:0]};
                    end
                    n_state = S_RM1;
                end
            end
            S_RM1: begin
                // push onto the free list
                n_we    = 1'b1;
                n_wa    = r_cur[IW-1:0];
                n_wd    = r_fh;
                p_we    = 1'b1;
                p_wa    = r_cur[IW-1:0];
                p_wd    = {1'b0, NONE};
                n_state = S_RM2;
            end
            S_RM2: begin
                if (r_fh != NONE) begin
                    p_we = 1'b1;
                    p_wa = r_fh[IW-1:0];
                    p_wd = {1'b0, NONE};
                end
                n_fh = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
                n_res_st   = ST_OK;
                n_res_pres = (r_nx != NONE);
                n_res_slot = (r_nx != NONE) ? r_nx[IW-1:0] : '0;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        if (load_out) begin
            n_ovalid = 1'b1;
            n_odata  = {2'b00, COUNT_W'(r_count), r_res_pres, SLOT_W'(r_res_slot),
                        r_res_val};
            n_ouser  = r_res_st;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_head   <= NONE;
            r_fh     <= '0;
            r_count  <= '0;
            r_sort   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_fh     <= n_fh;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_sort <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_prv      <= n_prv;
        r_nx       <= n_nx;
        r_res_st   <= n_res_st;
        r_res_val  <= n_res_val;
        r_res_slot <= n_res_slot;
        r_res_pres <= n_res_pres;
        r_odata    <= n_odata;
        r_ouser    <= n_ouser;
    end

`ifndef NO_ASSERTIONS
    // the element count never exceeds the node store
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("element count above capacity");

    // a successful add grows the list by one
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK1) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("add did not bump the count");

    // a new result word appears only from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result word without finished command");
`endif

endmodule
